/* hw/rtl/blram_pkg.sv */
// Shared constants and types for the bounded little-endian RAM.
// Used by the front end, the queue, the back end and the top level.
package blram_pkg;

  // Memory geometry: bytes are packed eight to a 64-bit word
  localparam int unsigned MEM_BYTES = 65536;
  localparam int unsigned MEM_WORDS = (MEM_BYTES + 7) / 8;
  localparam int unsigned WADDR_W   = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;
  localparam logic [64:0] MEM_LIMIT = 65'(MEM_BYTES);

  // Word queue between front and back
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  // Opcodes
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_STORE = 1'b1;

  // Fault codes
  localparam logic [1:0] FAULT_NONE  = 2'd0;
  localparam logic [1:0] FAULT_LOAD  = 2'd1;
  localparam logic [1:0] FAULT_STORE = 2'd2;

  // One classified access, as queued for the back end
  typedef struct packed {
    logic               is_store;
    logic               is_fault;
    logic [63:0]        faddr;     // base + offset on fault, else zero
    logic [WADDR_W-1:0] waddr;     // first word
    logic [WADDR_W-1:0] waddr_nxt; // second word of a spanning access
    logic [2:0]         shift;     // byte lane of the first byte
    logic [3:0]         nbytes;    // width, saturated to 8
    logic               spans;     // access crosses a word boundary
    logic [63:0]        wdata;
  } entry_t;

endpackage

/* hw/rtl/blram_front.sv */
// Front end: accepts access words, holds base_address, range-checks and
// classifies each access into a queue entry. Depends on blram_pkg.
module blram_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [63:0]          cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 opcode_i,
  input  logic [63:0]          offset_i,
  input  logic [3:0]           access_bytes_i,
  input  logic [63:0]          write_data_i,
  input  logic                 q_full_i,
  input  logic                 clr_busy_i,
  output logic                 push_o,
  output blram_pkg::entry_t    entry_o
);

  logic [63:0] base_q;
  logic [3:0]  nbytes;
  logic [64:0] end_sum;
  logic [3:0]  lane_end;
  logic        fits;

  // Base address register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= 64'h0000_0000_8000_0000;
    end else if (cfg_we_i) begin
      base_q <= cfg_wdata_i;
    end
  end

  // Widths above eight act as eight
  assign nbytes   = (access_bytes_i > 4'd8) ? 4'd8 : access_bytes_i;
  assign end_sum  = {1'b0, offset_i} + 65'(nbytes);
  assign fits     = (offset_i < 64'(blram_pkg::MEM_BYTES)) &&
                    (end_sum <= blram_pkg::MEM_LIMIT);
  assign lane_end = {1'b0, offset_i[2:0]} + nbytes;

  // No words are taken while the memory is being cleared
  assign in_ready_o = !q_full_i && !clr_busy_i;
  assign push_o     = in_valid_i && in_ready_o;

  // Classification
  always_comb begin
    entry_o.is_store  = (opcode_i == blram_pkg::OP_STORE);
    entry_o.is_fault  = !fits;
    entry_o.faddr     = fits ? 64'd0 : (base_q + offset_i);
    entry_o.waddr     = offset_i[3 +: blram_pkg::WADDR_W];
    entry_o.waddr_nxt = offset_i[3 +: blram_pkg::WADDR_W] + blram_pkg::WADDR_W'(1);
    entry_o.shift     = offset_i[2:0];
    entry_o.nbytes    = nbytes;
    entry_o.spans     = (lane_end > 4'd8);
    entry_o.wdata     = write_data_i;
  end

endmodule

/* hw/rtl/blram_queue.sv */
// Short FIFO of classified accesses between front and back end.
// Depends on blram_pkg for the entry type and depth.
module blram_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  blram_pkg::entry_t    entry_i,
  output logic                 full_o,
  input  logic                 pop_i,
  output logic                 valid_o,
  output blram_pkg::entry_t    head_o
);

  blram_pkg::entry_t                 slot_q [blram_pkg::QDEPTH];
  logic [blram_pkg::QPTR_W-1:0]      wr_ptr_q, wr_ptr_d;
  logic [blram_pkg::QPTR_W-1:0]      rd_ptr_q, rd_ptr_d;
  logic [blram_pkg::QCNT_W-1:0]      count_q, count_d;

  assign full_o  = (count_q == blram_pkg::QCNT_W'(blram_pkg::QDEPTH));
  assign valid_o = (count_q != '0);
  assign head_o  = slot_q[rd_ptr_q];

  // Pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == blram_pkg::QPTR_W'(blram_pkg::QDEPTH - 1)) ?
                 '0 : wr_ptr_q + blram_pkg::QPTR_W'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == blram_pkg::QPTR_W'(blram_pkg::QDEPTH - 1)) ?
                 '0 : rd_ptr_q + blram_pkg::QPTR_W'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + blram_pkg::QCNT_W'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - blram_pkg::QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

/* hw/rtl/blram_back.sv */
// Back end: clears the word memory after reset, then carries out queued
// loads, stores and faults and holds the result word. Depends on blram_pkg.
module blram_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 q_valid_i,
  input  blram_pkg::entry_t    head_i,
  output logic                 pop_o,
  output logic                 clr_busy_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [63:0]          read_data_o,
  output logic [1:0]           fault_o,
  output logic [63:0]          fault_address_o
);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_RUN   = 3'd1;
  localparam logic [2:0] ST_ST2   = 3'd2;
  localparam logic [2:0] ST_LD1   = 3'd3;
  localparam logic [2:0] ST_LD2   = 3'd4;

  localparam int unsigned AW = blram_pkg::WADDR_W;

  logic [2:0]    state_q, state_d;
  logic [AW-1:0] clr_idx_q, clr_idx_d;

  // Word memory with one port and a registered read
  logic [63:0]   mem_q [blram_pkg::MEM_WORDS];
  logic [63:0]   rd_q;
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_addr;
  logic [7:0]    mem_be;
  logic [63:0]   mem_wd;

  logic [63:0]   lo_q, lo_d;
  logic          out_valid_q;
  logic [63:0]   rdata_q, faddr_q;
  logic [1:0]    fault_q;

  logic          slot_free, finish;
  logic [7:0]    bmask;
  logic [63:0]   dmask;
  logic [127:0]  st_wide;
  logic [15:0]   st_be;
  logic [63:0]   ld_lo, ld_hi;
  logic [127:0]  ld_wide;
  logic [63:0]   ld_val;
  logic [63:0]   res_data;
  logic [1:0]    res_fault;

  // Result slot frees up in the cycle it is taken
  assign slot_free  = !out_valid_q || out_ready_i;
  assign clr_busy_o = (state_q == ST_CLEAR);

  // Byte lanes of the access, n ones from the bottom
  assign bmask = 8'((9'h1 << head_i.nbytes) - 9'h1);
  always_comb begin
    for (int b = 0; b < 8; b++) begin
      dmask[8*b +: 8] = {8{bmask[b]}};
    end
  end

  // Store data and byte enables spread over two words
  assign st_wide = {64'd0, head_i.wdata} << {head_i.shift, 3'b000};
  assign st_be   = {8'd0, bmask} << head_i.shift;

  // Load data: second word above first, shifted down to the first byte
  assign ld_lo   = (state_q == ST_LD2) ? lo_q : rd_q;
  assign ld_hi   = (state_q == ST_LD2) ? rd_q : 64'd0;
  assign ld_wide = {ld_hi, ld_lo} >> {head_i.shift, 3'b000};
  assign ld_val  = ld_wide[63:0] & dmask;

  // Result of the entry at the head
  always_comb begin
    if (head_i.is_fault) begin
      res_data  = 64'd0;
      res_fault = head_i.is_store ? blram_pkg::FAULT_STORE : blram_pkg::FAULT_LOAD;
    end else if (head_i.is_store) begin
      res_data  = 64'd0;
      res_fault = blram_pkg::FAULT_NONE;
    end else begin
      res_data  = ld_val;
      res_fault = blram_pkg::FAULT_NONE;
    end
  end

  // Sequencer
  always_comb begin
    state_d   = state_q;
    clr_idx_d = clr_idx_q;
    lo_d      = lo_q;
    finish    = 1'b0;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_addr  = head_i.waddr;
    mem_be    = 8'h00;
    mem_wd    = 64'd0;
    unique case (state_q)
      ST_CLEAR: begin
        mem_we   = 1'b1;
        mem_addr = clr_idx_q;
        mem_be   = 8'hff;
        if (clr_idx_q == AW'(blram_pkg::MEM_WORDS - 1)) begin
          state_d = ST_RUN;
        end else begin
          clr_idx_d = clr_idx_q + AW'(1);
        end
      end
      ST_RUN: begin
        // start only with a free result slot; nothing else fills it
        if (q_valid_i && slot_free) begin
          if (head_i.is_fault) begin
            finish = 1'b1;
          end else if (head_i.is_store) begin
            mem_we = 1'b1;
            mem_be = st_be[7:0];
            mem_wd = st_wide[63:0];
            if (head_i.spans) begin
              state_d = ST_ST2;
            end else begin
              finish = 1'b1;
            end
          end else begin
            mem_re  = 1'b1;
            state_d = ST_LD1;
          end
        end
      end
      ST_ST2: begin
        mem_we   = 1'b1;
        mem_addr = head_i.waddr_nxt;
        mem_be   = st_be[15:8];
        mem_wd   = st_wide[127:64];
        finish   = 1'b1;
        state_d  = ST_RUN;
      end
      ST_LD1: begin
        if (head_i.spans) begin
          lo_d     = rd_q;
          mem_re   = 1'b1;
          mem_addr = head_i.waddr_nxt;
          state_d  = ST_LD2;
        end else begin
          finish  = 1'b1;
          state_d = ST_RUN;
        end
      end
      ST_LD2: begin
        finish  = 1'b1;
        state_d = ST_RUN;
      end
      default: begin
        state_d = ST_RUN;
      end
    endcase
  end

  assign pop_o = finish;

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_idx_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_idx_q <= clr_idx_d;
      if (finish) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result and load staging registers
  always_ff @(posedge clk_i) begin
    lo_q <= lo_d;
    if (finish) begin
      rdata_q <= res_data;
      fault_q <= res_fault;
      faddr_q <= head_i.faddr;
    end
  end

  // Memory array
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      for (int b = 0; b < 8; b++) begin
        if (mem_be[b]) begin
          mem_q[mem_addr][8*b +: 8] <= mem_wd[8*b +: 8];
        end
      end
    end
    if (mem_re) begin
      rd_q <= mem_q[mem_addr];
    end
  end

  assign out_valid_o     = out_valid_q;
  assign read_data_o     = rdata_q;
  assign fault_o         = fault_q;
  assign fault_address_o = faddr_q;

endmodule

/* hw/rtl/bounded_little_endian_ram_top.sv */
// Top level of the bounded little-endian RAM: front end, queue, back end.
// Depends on blram_pkg, blram_front, blram_queue and blram_back.

// Byte-addressed RAM of blram_pkg::MEM_BYTES bytes, stored as 64-bit words
// in a single-port memory with a registered read. After reset the block
// clears the memory one word per cycle, MEM_WORDS words (8192 at 64 KiB),
// and takes no access word until that pass ends; base_address may be written
// meanwhile. In the back end a fault only sets the result, a store writes
// one word and a second when it crosses a word boundary, and a load reads
// one word and a second when it crosses one, as the memory has one port and
// a registered read. A two-entry queue lets the front end take words while
// the back end works or the result waits.
module bounded_little_endian_ram_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [63:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        opcode_i,
  input  logic [63:0] offset_i,
  input  logic [3:0]  access_bytes_i,
  input  logic [63:0] write_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [63:0] read_data_o,
  output logic [1:0]  fault_o,
  output logic [63:0] fault_address_o
);

  blram_pkg::entry_t push_entry, head_entry;
  logic              push, pop, q_full, q_valid, clr_busy;

  blram_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .opcode_i       (opcode_i),
    .offset_i       (offset_i),
    .access_bytes_i (access_bytes_i),
    .write_data_i   (write_data_i),
    .q_full_i       (q_full),
    .clr_busy_i     (clr_busy),
    .push_o         (push),
    .entry_o        (push_entry)
  );

  blram_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .full_o  (q_full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .head_o  (head_entry)
  );

  blram_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_valid_i       (q_valid),
    .head_i          (head_entry),
    .pop_o           (pop),
    .clr_busy_o      (clr_busy),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .read_data_o     (read_data_o),
    .fault_o         (fault_o),
    .fault_address_o (fault_address_o)
  );

endmodule
